### hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       msg_end;
    } sha_cmd_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

### hw/rtl/sha_front.sv
`timescale 1ns / 1ps

module sha_front #(
    parameter int DEPTH = sha_pkg::QueueDepth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sha_pkg::sha_cmd_t in_cmd,
    output logic              q_valid,
    input  logic              q_ready,
    output sha_pkg::sha_cmd_t q_cmd
);
    import sha_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_cmd_t        mem [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    // items with neither byte nor end are dropped here
    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push     = in_valid && in_ready && (in_cmd.has_byte || in_cmd.msg_end);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

### hw/rtl/sha_back.sv
`timescale 1ns / 1ps

module sha_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  sha_pkg::sha_cmd_t q_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       out_word,
    output logic [1:0]        out_index,
    output logic              out_last
);
    import sha_pkg::*;

    typedef enum logic [4:0] {
        ST_TAKE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [31:0]   w_reg [16];
    logic [5:0]    fill_reg;
    logic [63:0]   bits_reg;
    logic [63:0]   len_reg;
    logic [5:0]    rnd_reg;
    logic          closing_reg;
    logic [1:0]    oidx_reg;
    logic [7:0]    wbyte;
    logic          wen;
    logic [31:0]   t1, t2, s0, s1, wnew;
    logic          pad_first_reg;
    logic          spill_reg;
    logic          spill;

    // pad byte at position 56 or later: this block gets zeros, the length goes in the next one
    assign spill = spill_reg || (pad_first_reg && fill_reg >= LEN_POS);

    // the byte to write into the block this cycle
    always_comb
    begin
        wen   = 1'b0;
        wbyte = 8'h00;
        case (state_reg)
            ST_TAKE:
            begin
                wen   = q_valid && q_cmd.has_byte;
                wbyte = q_cmd.data_byte;
            end
            ST_PAD:
            begin
                wen = 1'b1;
                if (fill_reg >= LEN_POS && !spill)
                begin
                    wbyte = len_reg[8'(63 - 8 * (fill_reg - LEN_POS)) -: 8];
                end
                else
                begin
                    wbyte = 8'h00;
                end
            end
            default:
            begin
                wen = 1'b0;
            end
        endcase
    end

    assign q_ready = (state_reg == ST_TAKE);

    assign s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = s1 + w_reg[9] + s0 + w_reg[0];
    assign t1 = v_reg[7] + (ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg]
              + w_reg[0];
    assign t2 = (ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_TAKE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.has_byte && fill_reg == 6'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (q_cmd.msg_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!closing_reg)
                begin
                    state_next = ST_TAKE;
                end
                else if (fill_reg == 6'd0 && len_reg[0] == 1'b1)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (out_ready && oidx_reg == 2'd3)
                begin
                    state_next = ST_TAKE;
                end
            end
            default:
            begin
                state_next = ST_TAKE;
            end
        endcase
    end

    // len_reg[0] marks that the length bytes went out (bit lengths are multiples of 8)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_TAKE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            len_reg     <= '0;
            rnd_reg     <= '0;
            closing_reg <= 1'b0;
            oidx_reg    <= '0;
            spill_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_TAKE:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd.has_byte)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                        end
                        if (q_cmd.msg_end)
                        begin
                            closing_reg <= 1'b1;
                            len_reg     <= bits_reg + (q_cmd.has_byte ? 64'd8 : 64'd0);
                            if (!(q_cmd.has_byte && fill_reg == 6'd63))
                            begin
                                fill_reg <= fill_reg + 6'(q_cmd.has_byte);
                            end
                        end
                        else if (q_cmd.has_byte)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                        end
                    end
                    rnd_reg <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg  <= rnd_reg + 6'd1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                        v_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    rnd_reg   <= '0;
                    spill_reg <= 1'b0;
                end
                ST_PAD:
                begin
                    fill_reg  <= fill_reg + 6'd1;
                    spill_reg <= spill;
                    if (fill_reg == 6'd63 && !spill)
                    begin
                        len_reg[0] <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 2'd1;
                        if (oidx_reg == 2'd3)
                        begin
                            closing_reg <= 1'b0;
                            bits_reg    <= '0;
                            fill_reg    <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= INIT_H[i];
                            end
                        end
                    end
                end
                default:
                begin
                    rnd_reg <= '0;
                end
            endcase
        end
    end

    // pad byte goes in at the first pad cycle of a message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_first_reg <= 1'b0;
        end
        else if (state_reg == ST_TAKE && q_valid && q_cmd.msg_end)
        begin
            pad_first_reg <= 1'b1;
        end
        else if (state_reg == ST_PAD)
        begin
            pad_first_reg <= 1'b0;
        end
    end

    // message schedule as a 16-word window, shifted once per round
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            case (fill_reg[1:0])
                2'd0:    w_reg[fill_reg[5:2]][31:24] <= (state_reg == ST_PAD && pad_first_reg)
                                                        ? PAD_BYTE : wbyte;
                2'd1:    w_reg[fill_reg[5:2]][23:16] <= (state_reg == ST_PAD && pad_first_reg)
                                                        ? PAD_BYTE : wbyte;
                2'd2:    w_reg[fill_reg[5:2]][15:8]  <= (state_reg == ST_PAD && pad_first_reg)
                                                        ? PAD_BYTE : wbyte;
                default: w_reg[fill_reg[5:2]][7:0]   <= (state_reg == ST_PAD && pad_first_reg)
                                                        ? PAD_BYTE : wbyte;
            endcase
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wnew;
        end
    end

    assign out_valid = (state_reg == ST_OUT);
    assign out_index = oidx_reg;
    assign out_last  = (oidx_reg == 2'd3);
    assign out_word  = {h_reg[{oidx_reg, 1'b0}], h_reg[{oidx_reg, 1'b1}]};

endmodule

### hw/rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps

// sha-256 over a byte stream
// s_axis: one message byte per word; tdata = data_byte, tuser = {msg_end, has_byte}
// a word with msg_end closes the message (with or without a byte of its own)
// m_axis: four 64-bit digest words, big-endian, tuser = word index, tlast on the fourth
// a small queue in front takes bytes while a block compresses
// each byte is written into the block while the back end waits for input; every 64th byte starts 64 rounds
// and one add step, all on the single round unit
// closing a message adds padding and up to two compressions,
// then the digest words leave one per cycle as m_axis_tready allows
// while m_axis is stalled the digest holds and no new byte is processed,
// the queue fills and then s_axis_tready drops
// reset loads the initial vector and empties the queue and block
module sha256_stream_hasher #(
    parameter int QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] has_byte, [1] msg_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast
);
    import sha_pkg::*;

    sha_cmd_t in_cmd, q_cmd;
    logic     q_valid, q_ready;

    assign in_cmd.data_byte = s_axis_tdata;
    assign in_cmd.has_byte  = s_axis_tuser[0];
    assign in_cmd.msg_end   = s_axis_tuser[1];

    sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    sha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_index (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
